// ----- sv/ipcd_pkg.sv -----
package ipcd_pkg;

    localparam int TICKS_W    = 24;
    localparam int CODE_W     = 8;
    localparam int LED_W      = 3;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CMP_W      = 32;

    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_slot SLOT_MAX = t_slot'(63);

    localparam logic REQ_EDGE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam t_cfg_idx CFG_ZERO_LOW  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_ZERO_HIGH = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_ONE_LOW   = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_ONE_HIGH  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_CODE_A    = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_CODE_B    = t_cfg_idx'(5);
    localparam t_cfg_idx CFG_CODE_C    = t_cfg_idx'(6);

    localparam logic [TICKS_W-1:0] ZERO_LOW_RST  = TICKS_W'(1000);
    localparam logic [TICKS_W-1:0] ZERO_HIGH_RST = TICKS_W'(1200);
    localparam logic [TICKS_W-1:0] ONE_LOW_RST   = TICKS_W'(2000);
    localparam logic [TICKS_W-1:0] ONE_HIGH_RST  = TICKS_W'(2300);
    localparam logic [CODE_W-1:0]  CODE_A_RST    = CODE_W'(12);
    localparam logic [CODE_W-1:0]  CODE_B_RST    = CODE_W'(24);
    localparam logic [CODE_W-1:0]  CODE_C_RST    = CODE_W'(94);

    localparam logic [LED_W-1:0] MASK_NONE = 3'b000;
    localparam logic [LED_W-1:0] MASK_A    = 3'b001;
    localparam logic [LED_W-1:0] MASK_B    = 3'b010;
    localparam logic [LED_W-1:0] MASK_C    = 3'b100;

    typedef struct packed {
        logic               req_type;
        logic [TICKS_W-1:0] interval_ticks;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0] decoded_command;
        logic [LED_W-1:0]  toggle_mask;
        logic [LED_W-1:0]  led_state;
    } t_out;

    typedef struct packed {
        logic [TICKS_W-1:0] zero_low;
        logic [TICKS_W-1:0] zero_high;
        logic [TICKS_W-1:0] one_low;
        logic [TICKS_W-1:0] one_high;
        logic [CODE_W-1:0]  code_a;
        logic [CODE_W-1:0]  code_b;
        logic [CODE_W-1:0]  code_c;
    } t_cfg;

    // per-cycle strobes from the input stage
    typedef struct packed {
        logic ev_edge;  // edge item leaves the input register
        logic ev_tmo;   // timeout item while capturing leaves the input register
    } t_ctl;

endpackage

// ----- sv/ipcd_cfg.sv -----
module ipcd_cfg import ipcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZERO_LOW:  n_cfg.zero_low  = i_cfg_data[TICKS_W-1:0];
                CFG_ZERO_HIGH: n_cfg.zero_high = i_cfg_data[TICKS_W-1:0];
                CFG_ONE_LOW:   n_cfg.one_low   = i_cfg_data[TICKS_W-1:0];
                CFG_ONE_HIGH:  n_cfg.one_high  = i_cfg_data[TICKS_W-1:0];
                CFG_CODE_A:    n_cfg.code_a    = i_cfg_data[CODE_W-1:0];
                CFG_CODE_B:    n_cfg.code_b    = i_cfg_data[CODE_W-1:0];
                CFG_CODE_C:    n_cfg.code_c    = i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_low  <= ZERO_LOW_RST;
            r_cfg.zero_high <= ZERO_HIGH_RST;
            r_cfg.one_low   <= ONE_LOW_RST;
            r_cfg.one_high  <= ONE_HIGH_RST;
            r_cfg.code_a    <= CODE_A_RST;
            r_cfg.code_b    <= CODE_B_RST;
            r_cfg.code_c    <= CODE_C_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/ipcd_capture.sv -----
module ipcd_capture import ipcd_pkg::*; #(
    parameter int FIRST_COMMAND_SLOT = 17,
    parameter int COMMAND_BITS       = 8,
    parameter int INTERVAL_WIDTH     = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic [TICKS_W-1:0]        i_ticks,
    output logic                      o_capturing,
    output logic [INTERVAL_WIDTH-1:0] o_ivl [COMMAND_BITS]
);

    logic                      r_capturing;
    logic                      n_capturing;
    t_slot                     r_slot;
    t_slot                     n_slot;
    logic [INTERVAL_WIDTH-1:0] r_ivl [COMMAND_BITS];
    logic [INTERVAL_WIDTH-1:0] n_ivl [COMMAND_BITS];
    logic [CMP_W-1:0]          ticks_ext;

    assign ticks_ext = CMP_W'(i_ticks);

    always_comb begin
        n_capturing = r_capturing;
        n_slot      = r_slot;
        n_ivl       = r_ivl;
        if (i_ctl.ev_tmo) begin
            n_capturing = 1'b0;
            n_slot      = '0;
        end else if (i_ctl.ev_edge) begin
            if (!r_capturing) begin
                // first edge of a frame only opens capture
                n_capturing = 1'b1;
            end else begin
                for (int i = 0; i < COMMAND_BITS; i++) begin
                    if (r_slot == t_slot'(FIRST_COMMAND_SLOT + i)) begin
                        n_ivl[i] = ticks_ext[INTERVAL_WIDTH-1:0];
                    end
                end
                if (r_slot != SLOT_MAX) begin
                    n_slot = r_slot + t_slot'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_slot      <= '0;
            for (int i = 0; i < COMMAND_BITS; i++) begin
                r_ivl[i] <= '0;
            end
        end else begin
            r_capturing <= n_capturing;
            r_slot      <= n_slot;
            r_ivl       <= n_ivl;
        end
    end

    assign o_capturing = r_capturing;
    assign o_ivl       = r_ivl;

`ifndef SYNTH
    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_capturing |-> (r_slot == '0))
        else $error("edge slot nonzero while idle");

    a_tmo_only_capturing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ev_tmo |-> r_capturing)
        else $error("timeout processed while idle");
`endif

endmodule

// ----- sv/ipcd_classify.sv -----
module ipcd_classify import ipcd_pkg::*; #(
    parameter int COMMAND_BITS   = 8,
    parameter int INTERVAL_WIDTH = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  t_cfg                      i_cfg,
    input  logic [INTERVAL_WIDTH-1:0] i_ivl [COMMAND_BITS],
    input  logic                      i_out_stall,
    output logic                      o_free,
    output logic                      o_out_valid,
    output t_out                      o_out_data
);

    logic [CODE_W-1:0] r_held;
    logic [CODE_W-1:0] n_held;
    logic [LED_W-1:0]  r_level;
    logic [LED_W-1:0]  n_level;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out              r_out;
    logic [CODE_W-1:0] cmd;
    logic [LED_W-1:0]  mask;
    logic [CMP_W-1:0]  v;

    // classify the kept intervals into the held command
    always_comb begin
        cmd = r_held;
        v   = '0;
        for (int b = 0; b < COMMAND_BITS; b++) begin
            v = CMP_W'(i_ivl[b]);
            if (v >= CMP_W'(i_cfg.zero_low) && v <= CMP_W'(i_cfg.zero_high)) begin
                cmd[b] = 1'b0;
            end else if (v >= CMP_W'(i_cfg.one_low) && v <= CMP_W'(i_cfg.one_high)) begin
                cmd[b] = 1'b1;
            end
        end
    end

    always_comb begin
        priority if (cmd == i_cfg.code_a) begin
            mask = MASK_A;
        end else if (cmd == i_cfg.code_b) begin
            mask = MASK_B;
        end else if (cmd == i_cfg.code_c) begin
            mask = MASK_C;
        end else begin
            mask = MASK_NONE;
        end
    end

    assign o_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_held      = r_held;
        n_level     = r_level;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_ctl.ev_tmo) begin
            n_out_valid = 1'b1;
            n_level     = r_level ^ mask;
            n_held      = (mask != MASK_NONE) ? '0 : cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ev_tmo) begin
            r_out.decoded_command <= cmd;
            r_out.toggle_mask     <= mask;
            r_out.led_state       <= r_level ^ mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ev_tmo |-> o_free)
        else $error("result register overwritten while stalled");

    a_mask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ev_tmo |=> $onehot0(r_out.toggle_mask)
            && (r_out.led_state == r_level))
        else $error("bad toggle mask or led state in result");
`endif

endmodule

// ----- sv/ir_pulse_command_decoder_core.sv -----
// NEC-style IR command decoder.
// Input channel (i_in_valid / o_in_stall / i_in_data): one item per falling
// edge (req_type edge, interval_ticks since previous edge) or per frame
// timeout (req_type timeout). Edges produce no result; a timeout while a
// frame is being captured produces one result on the output channel
// (o_out_valid / i_out_stall / o_out_data): decoded command, toggle mask and
// LED levels. A timeout while idle is dropped.
// An accepted item is registered in the input register and processed from
// there; a timeout's result is registered in the result register.
// Throughput: one item per cycle unless a timeout waits on a stalled receiver,
// set by the combinational compare/update between input and result registers.
// When the receiver stalls, the result register holds; edge items keep
// flowing, and a timeout during capture waits in the input register until
// the result register frees, with o_in_stall high for as long as it waits.
// Synchronous reset (i_rst_n low) empties both registers, returns to idle,
// clears stored intervals, held command and LED levels, and loads the
// default thresholds and codes. Configuration writes (i_cfg_we) take effect
// at the next edge and are meant to happen only while the block is idle.
module ir_pulse_command_decoder_core import ipcd_pkg::*; #(
    parameter int FIRST_COMMAND_SLOT = 17,
    parameter int COMMAND_BITS       = 8,
    parameter int INTERVAL_WIDTH     = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                      r_in_valid;
    logic                      n_in_valid;
    t_in                       r_in;
    logic                      load;
    logic                      advance;
    logic                      capturing;
    logic                      need_out;
    logic                      free;
    t_ctl                      ctl;
    t_cfg                      cfg;
    logic [INTERVAL_WIDTH-1:0] ivl [COMMAND_BITS];

    assign need_out   = (r_in.req_type == REQ_TIMEOUT) && capturing;
    assign advance    = r_in_valid && (!need_out || free);
    assign o_in_stall = r_in_valid && !advance;
    assign load       = i_in_valid && !o_in_stall;
    assign n_in_valid = load || (r_in_valid && !advance);

    assign ctl.ev_edge = advance && (r_in.req_type == REQ_EDGE);
    assign ctl.ev_tmo  = advance && need_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in <= i_in_data;
        end
    end

    ipcd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ipcd_capture #(
        .FIRST_COMMAND_SLOT (FIRST_COMMAND_SLOT),
        .COMMAND_BITS       (COMMAND_BITS),
        .INTERVAL_WIDTH     (INTERVAL_WIDTH)
    ) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_ticks     (r_in.interval_ticks),
        .o_capturing (capturing),
        .o_ivl       (ivl)
    );

    ipcd_classify #(
        .COMMAND_BITS   (COMMAND_BITS),
        .INTERVAL_WIDTH (INTERVAL_WIDTH)
    ) u_classify (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_cfg       (cfg),
        .i_ivl       (ivl),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && need_out && o_out_valid))
        else $error("input stalled without a blocked timeout");
`endif

endmodule
